@@ src/delimited_field_projector_defines.svh @@
// Assertion helpers for the self-checks of the top-level block.
`ifndef DELIMITED_FIELD_PROJECTOR_DEFINES_SVH
`define DELIMITED_FIELD_PROJECTOR_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define DFP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define DFP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/dfp_pkg.sv @@
package dfp_pkg;

	localparam int DFP_MAX_COLUMNS  = 32;
	localparam int DFP_FIELD_BUFFER = 512;

	localparam logic [7:0] DELIM = 8'h7C;
	localparam logic [7:0] NUL   = 8'h00;

	// field counter width and saturation point
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] CNT_TOP = 6'd63;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// configuration register indexes
	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_COLUMNS  = 2'd1;
	localparam logic [1:0] REG_KEY      = 2'd2;
	localparam logic [1:0] REG_CAPACITY = 2'd3;

	// queue entry kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TERM = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [5:0]  column_count;
		logic [4:0]  key_column;
		logic [15:0] capacity;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic [CNT_W-1:0] col;
		logic [15:0]      em;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

@@ src/dfp_front.sv @@
module dfp_front import dfp_pkg::*; #(
	parameter int MAX_COLUMNS  = DFP_MAX_COLUMNS,
	parameter int FIELD_BUFFER = DFP_FIELD_BUFFER
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       end_of_record,
	input  logic [4:0] select_index,
	input  qstat_t     qstat,
	output push_t      push
);

	localparam int FbW = $clog2(FIELD_BUFFER);
	localparam logic [FbW-1:0] FbTop = FbW'(FIELD_BUFFER - 1);
	localparam logic [CNT_W-1:0] MaxCol = CNT_W'(MAX_COLUMNS);

	logic [CNT_W-1:0] fc_q, fc_d;
	logic [FbW-1:0]   fb_q, fb_d;
	logic [15:0]      em_q, em_d;
	logic             term_q, term_d;
	logic             first_q, first_d;
	logic [4:0]       sel_q, sel_d;

	logic [CNT_W-1:0] cols_use;
	logic [4:0]       sel_now;
	logic             proj, room, accept;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign cols_use = (cfg.column_count > MaxCol) ? MaxCol : cfg.column_count;
	assign sel_now  = first_q ? select_index : sel_q;
	assign proj     = (fc_q < cols_use) && (fc_q != {1'b0, cfg.key_column});
	assign room     = (cfg.capacity != 16'd0) && (em_q < cfg.capacity - 16'd1);

	always_comb begin
		fc_d = fc_q;
		fb_d = fb_q;
		em_d = em_q;
		term_d = term_q;
		first_d = first_q;
		sel_d = sel_q;
		push.valid = 1'b0;
		push.entry.kind = KIND_BYTE;
		push.entry.data = char_byte;
		push.entry.col = fc_q;
		push.entry.em = em_q;
		if (accept) begin
			first_d = 1'b0;
			sel_d = sel_now;
			priority if (end_of_record) begin
				push.valid = 1'b1;
				push.entry.kind = KIND_TERM;
				fc_d = '0;
				fb_d = '0;
				em_d = '0;
				term_d = 1'b0;
				first_d = 1'b1;
			end else if (term_q) begin
				// drop bytes after an early end
			end else if (char_byte == NUL) begin
				term_d = 1'b1;
			end else if (char_byte == DELIM) begin
				if (!cfg.mode && proj && room) begin
					push.valid = 1'b1;
					em_d = em_q + 16'd1;
				end
				fc_d = (fc_q != CNT_TOP) ? fc_q + 1'b1 : fc_q;
				fb_d = '0;
			end else if (!cfg.mode) begin
				if (proj && fb_q < FbTop) begin
					if (room) begin
						push.valid = 1'b1;
						em_d = em_q + 16'd1;
					end
					fb_d = fb_q + 1'b1;
				end
			end else if (fc_q == {1'b0, sel_now} && room) begin
				push.valid = 1'b1;
				em_d = em_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
			fb_q <= '0;
			em_q <= '0;
			term_q <= 1'b0;
			first_q <= 1'b1;
			sel_q <= '0;
		end else begin
			fc_q <= fc_d;
			fb_q <= fb_d;
			em_q <= em_d;
			term_q <= term_d;
			first_q <= first_d;
			sel_q <= sel_d;
		end
	end

endmodule

@@ src/dfp_queue.sv @@
module dfp_queue import dfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output entry_t head,
	output qstat_t qstat
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign head = mem_q[rd_q];
	assign qstat.full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(pop);
		end
	end

endmodule

@@ src/dfp_back.sv @@
module dfp_back import dfp_pkg::*; #(
	parameter int MAX_COLUMNS = DFP_MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  entry_t      head,
	input  qstat_t      qstat,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam logic B_IDLE = 1'b0;
	localparam logic B_TERM = 1'b1;
	localparam logic [CNT_W-1:0] MaxCol = CNT_W'(MAX_COLUMNS);

	logic             st_q, st_d;
	logic [CNT_W-1:0] col_q, col_d;
	logic [15:0]      em_q, em_d;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_bv_q, out_last_q;
	logic [15:0] out_len_q;

	logic        can_load, load, ld_bv, ld_last;
	logic [7:0]  ld_byte;
	logic [15:0] ld_len;
	logic [CNT_W-1:0] cols_use;
	logic        room, emit_ok;

	assign can_load = !out_valid_q || m_tready;
	assign cols_use = (cfg.column_count > MaxCol) ? MaxCol : cfg.column_count;
	assign room     = (cfg.capacity != 16'd0) && (em_q < cfg.capacity - 16'd1);
	assign emit_ok  = (col_q != {1'b0, cfg.key_column}) && room;

	always_comb begin
		st_d = st_q;
		col_d = col_q;
		em_d = em_q;
		pop = 1'b0;
		load = 1'b0;
		ld_byte = head.data;
		ld_bv = 1'b1;
		ld_last = 1'b0;
		ld_len = '0;
		unique case (st_q)
			B_IDLE: begin
				if (!qstat.empty && can_load) begin
					pop = 1'b1;
					if (head.kind == KIND_BYTE) begin
						load = 1'b1;
					end else begin
						st_d = B_TERM;
						col_d = head.col;
						em_d = head.em;
					end
				end
			end
			B_TERM: begin
				if (!cfg.mode && col_q < cols_use) begin
					if (!emit_ok) begin
						col_d = col_q + 1'b1;
					end else if (can_load) begin
						load = 1'b1;
						ld_byte = DELIM;
						em_d = em_q + 16'd1;
						col_d = col_q + 1'b1;
					end
				end else if (can_load) begin
					load = 1'b1;
					ld_byte = NUL;
					ld_bv = 1'b0;
					ld_last = 1'b1;
					ld_len = em_q;
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			col_q <= '0;
			em_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			col_q <= col_d;
			em_q <= em_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= ld_byte;
			out_bv_q <= ld_bv;
			out_last_q <= ld_last;
			out_len_q <= ld_len;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_len_q, out_byte_q};
	assign m_tuser  = out_bv_q;
	assign m_tlast  = out_last_q;

endmodule

@@ src/delimited_field_projector.sv @@
// Channel | Dir | Contents
// --------+-----+----------------------------------------------------------------
// s_*     | in  | tdata char_byte, tlast end_of_record, tuser select_index
// m_*     | out | tdata out_byte/out_length, tuser byte_valid, tlast final marker
// cfg_*   | in  | register writes: mode, column_count, key_column, capacity
//
// Cycles: one record byte per cycle while the four-entry queue has room;
// each byte yields at most one result. On a terminator the back end leaves
// the queue, then in mode 0 pads the remaining columns up to the column
// count, then sends the marker. Reset clears record state and sets the
// register defaults. A stalled m_tready holds the output register; the
// queue absorbs up to four entries before s_tready drops.
`include "delimited_field_projector_defines.svh"

module delimited_field_projector import dfp_pkg::*; #(
	parameter int MAX_COLUMNS  = DFP_MAX_COLUMNS,
	parameter int FIELD_BUFFER = DFP_FIELD_BUFFER
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,
	input  logic [4:0]  s_tuser,   // [4:0] select_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_length
	output logic        m_tuser,   // [0] byte_valid
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t   cfg_q;
	push_t  push;
	entry_t head;
	qstat_t qstat;
	logic   pop;

	// Register file: the user must write it only between records; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 1'b0;
			cfg_q.column_count <= 6'd1;
			cfg_q.key_column <= 5'd0;
			cfg_q.capacity <= 16'd512;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:     cfg_q.mode <= cfg_data[0];
				REG_COLUMNS:  cfg_q.column_count <= cfg_data[5:0];
				REG_KEY:      cfg_q.key_column <= cfg_data[4:0];
				REG_CAPACITY: cfg_q.capacity <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: classify each byte, track field position and byte budget.
	dfp_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.FIELD_BUFFER(FIELD_BUFFER)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.char_byte(s_tdata),
		.end_of_record(s_tlast),
		.select_index(s_tuser),
		.qstat(qstat),
		.push(push)
	);

	// Queue: decouple front and back so each stalls on its own.
	dfp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	// Back: emit bytes, pad missing columns on a terminator in mode 0, close with marker.
	dfp_back #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Byte results never carry a length and never close the record.
	`DFP_ASSERT_IMPLY(a_byte_no_len, m_tvalid && m_tuser, (m_tdata[23:8] == 16'd0) && !m_tlast, "byte result carries length or last")
	// The front never pushes into a full queue.
	`DFP_ASSERT_ALWAYS(a_no_overflow, !(push.valid && qstat.full), "push into full queue")
	// The budget is capacity minus one, so a length never reaches all ones.
	`DFP_ASSERT_IMPLY(a_len_bound, m_tvalid && m_tlast, m_tdata[23:8] != 16'hFFFF, "marker length out of range")

endmodule
